// File: rtl/core/ffca_pkg.sv
// ----------------------------------------------------------------------------
// ffca_pkg
// Shared constants, types and helpers for the first-fit capacity allocator.
// ----------------------------------------------------------------------------
package ffca_pkg;

    localparam int SLOTS   = 1024;
    localparam int CAP_W   = 32;
    localparam int SLOT_W  = 11;
    localparam int LEVELS  = $clog2(SLOTS);
    localparam int NODE_W  = LEVELS + 1;
    localparam int ROW_W   = 2 * CAP_W;
    localparam int LVL_W   = $clog2(LEVELS);

    localparam logic [SLOT_W-1:0] COUNT_RESET = SLOT_W'(1024);

    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_ALLOC = 1'b1;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_WALK,
        ST_ASCEND,
        ST_FINISH
    } state_t;

    // One row holds the two children of tree node k: left (2k) low, right (2k+1) high.
    typedef struct packed {
        logic              we;
        logic [LEVELS-1:0] waddr;
        logic [ROW_W-1:0]  wdata;
        logic [LEVELS-1:0] raddr;
    } ram_req_t;

    typedef struct packed {
        logic              valid;
        logic [SLOT_W-1:0] slot;
    } result_t;

    function automatic logic [CAP_W-1:0] cap_max(input logic [CAP_W-1:0] a,
                                                 input logic [CAP_W-1:0] b);
        return (a > b) ? a : b;
    endfunction

endpackage

// File: rtl/core/ffca_row_ram.sv
// ----------------------------------------------------------------------------
// ffca_row_ram
// Simple dual-port RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
module ffca_row_ram #(
    parameter int DEPTH = 1024,
    parameter int WIDTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule

// File: rtl/core/ffca_walker.sv
// ----------------------------------------------------------------------------
// ffca_walker
// Tree sequencer: clears the row RAM, walks root to leaf one row per cycle,
// then writes the refreshed maxima back leaf to root one row per cycle unless no slot fits.
// ----------------------------------------------------------------------------
module ffca_walker (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic                        in_opcode,
    input  logic [ffca_pkg::SLOT_W-1:0] in_slot,
    input  logic [ffca_pkg::CAP_W-1:0]  in_amount,
    input  logic [ffca_pkg::SLOT_W-1:0] slot_count,
    output ffca_pkg::result_t           res,
    input  logic                        res_ready,
    output ffca_pkg::ram_req_t          ram_req,
    input  logic [ffca_pkg::ROW_W-1:0]  ram_rdata
);

    ffca_pkg::state_t state_reg, state_next;

    logic [ffca_pkg::LEVELS-1:0] clr_reg, clr_next;
    logic [ffca_pkg::NODE_W-1:0] node_reg, node_next;
    logic [ffca_pkg::LEVELS-1:0] path_reg, path_next;
    logic [ffca_pkg::LVL_W-1:0]  level_reg, level_next;
    logic                        op_reg, op_next;
    logic [ffca_pkg::CAP_W-1:0]  amount_reg, amount_next;
    logic [ffca_pkg::CAP_W-1:0]  val_reg, val_next;
    logic [ffca_pkg::CAP_W-1:0]  root_reg, root_next;
    logic [ffca_pkg::SLOT_W-1:0] slot_res_reg, slot_res_next;
    logic [ffca_pkg::ROW_W-1:0]  stack_reg [ffca_pkg::LEVELS];

    logic                        accept;
    logic                        load_ok;
    logic                        root_fit;
    logic                        last_step;
    logic [ffca_pkg::NODE_W-1:0] tgt_node;
    logic [ffca_pkg::CAP_W-1:0]  left_cap;
    logic [ffca_pkg::CAP_W-1:0]  right_cap;
    logic                        go_right;
    logic [ffca_pkg::NODE_W-1:0] child;
    logic [ffca_pkg::CAP_W-1:0]  chosen_cap;
    logic [ffca_pkg::SLOT_W-1:0] pick_slot;
    logic                        slot_fit;
    logic [ffca_pkg::ROW_W-1:0]  asc_row;
    logic [ffca_pkg::CAP_W-1:0]  asc_max;
    logic                        push;
    logic                        pop;

    assign in_ready  = (state_reg == ffca_pkg::ST_IDLE);
    assign accept    = in_valid && in_ready;
    assign load_ok   = (in_slot != '0) && (in_slot <= ffca_pkg::SLOT_W'(ffca_pkg::SLOTS));
    assign root_fit  = (root_reg >= in_amount);
    assign tgt_node  = ffca_pkg::NODE_W'(ffca_pkg::SLOTS - 1) + ffca_pkg::NODE_W'(in_slot);
    assign last_step = (level_reg == ffca_pkg::LVL_W'(ffca_pkg::LEVELS - 1));

    // descent decision on the row just read
    assign left_cap   = ram_rdata[ffca_pkg::CAP_W-1:0];
    assign right_cap  = ram_rdata[ffca_pkg::ROW_W-1:ffca_pkg::CAP_W];
    assign go_right   = (op_reg == ffca_pkg::OP_ALLOC) ? (left_cap < amount_reg)
                                                       : path_reg[ffca_pkg::LEVELS-1];
    assign child      = {node_reg[ffca_pkg::LEVELS-1:0], go_right};
    assign chosen_cap = go_right ? right_cap : left_cap;
    assign pick_slot  = ffca_pkg::SLOT_W'(child[ffca_pkg::LEVELS-1:0]) + ffca_pkg::SLOT_W'(1);
    assign slot_fit   = (pick_slot <= slot_count);

    // ascent: splice the new child value into the saved row
    assign asc_row = node_reg[0]
                   ? {val_reg, stack_reg[0][ffca_pkg::CAP_W-1:0]}
                   : {stack_reg[0][ffca_pkg::ROW_W-1:ffca_pkg::CAP_W], val_reg};
    assign asc_max = ffca_pkg::cap_max(asc_row[ffca_pkg::CAP_W-1:0],
                                       asc_row[ffca_pkg::ROW_W-1:ffca_pkg::CAP_W]);

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ffca_pkg::ST_CLEAR:
            begin
                if (clr_reg == '1)
                begin
                    state_next = ffca_pkg::ST_IDLE;
                end
            end
            ffca_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    if (in_opcode == ffca_pkg::OP_LOAD)
                    begin
                        state_next = load_ok ? ffca_pkg::ST_WALK : ffca_pkg::ST_IDLE;
                    end
                    else
                    begin
                        state_next = root_fit ? ffca_pkg::ST_WALK : ffca_pkg::ST_FINISH;
                    end
                end
            end
            ffca_pkg::ST_WALK:
            begin
                if (last_step)
                begin
                    if (op_reg == ffca_pkg::OP_ALLOC && !slot_fit)
                    begin
                        state_next = ffca_pkg::ST_FINISH;
                    end
                    else
                    begin
                        state_next = ffca_pkg::ST_ASCEND;
                    end
                end
            end
            ffca_pkg::ST_ASCEND:
            begin
                if (last_step)
                begin
                    state_next = (op_reg == ffca_pkg::OP_ALLOC) ? ffca_pkg::ST_FINISH
                                                                : ffca_pkg::ST_IDLE;
                end
            end
            ffca_pkg::ST_FINISH:
            begin
                if (res_ready)
                begin
                    state_next = ffca_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = ffca_pkg::ST_IDLE;
            end
        endcase
    end

    // datapath and outputs
    always_comb
    begin
        clr_next      = clr_reg;
        node_next     = node_reg;
        path_next     = path_reg;
        level_next    = level_reg;
        op_next       = op_reg;
        amount_next   = amount_reg;
        val_next      = val_reg;
        root_next     = root_reg;
        slot_res_next = slot_res_reg;
        push          = 1'b0;
        pop           = 1'b0;
        ram_req.we    = 1'b0;
        ram_req.waddr = clr_reg;
        ram_req.wdata = '0;
        ram_req.raddr = ffca_pkg::LEVELS'(1);
        case (state_reg)
            ffca_pkg::ST_CLEAR:
            begin
                ram_req.we = 1'b1;
                clr_next   = clr_reg + ffca_pkg::LEVELS'(1);
            end
            ffca_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    op_next       = in_opcode;
                    amount_next   = in_amount;
                    path_next     = tgt_node[ffca_pkg::LEVELS-1:0];
                    node_next     = ffca_pkg::NODE_W'(1);
                    level_next    = '0;
                    slot_res_next = '0;
                end
            end
            ffca_pkg::ST_WALK:
            begin
                push          = 1'b1;
                ram_req.raddr = child[ffca_pkg::LEVELS-1:0];
                node_next     = child;
                path_next     = {path_reg[ffca_pkg::LEVELS-2:0], 1'b0};
                level_next    = last_step ? '0 : level_reg + ffca_pkg::LVL_W'(1);
                if (last_step)
                begin
                    if (op_reg == ffca_pkg::OP_ALLOC)
                    begin
                        val_next      = chosen_cap - amount_reg;
                        slot_res_next = slot_fit ? pick_slot : '0;
                    end
                    else
                    begin
                        val_next = amount_reg;
                    end
                end
            end
            ffca_pkg::ST_ASCEND:
            begin
                pop           = 1'b1;
                ram_req.we    = 1'b1;
                ram_req.waddr = node_reg[ffca_pkg::LEVELS:1];
                ram_req.wdata = asc_row;
                val_next      = asc_max;
                node_next     = node_reg >> 1;
                level_next    = last_step ? '0 : level_reg + ffca_pkg::LVL_W'(1);
                if (last_step)
                begin
                    root_next = asc_max;
                end
            end
            default:
            begin
            end
        endcase
    end

    assign res.valid = (state_reg == ffca_pkg::ST_FINISH);
    assign res.slot  = slot_res_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ffca_pkg::ST_CLEAR;
            clr_reg   <= '0;
            level_reg <= '0;
            root_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            clr_reg   <= clr_next;
            level_reg <= level_next;
            root_reg  <= root_next;
        end
    end

    always_ff @(posedge clk)
    begin
        node_reg     <= node_next;
        path_reg     <= path_next;
        op_reg       <= op_next;
        amount_reg   <= amount_next;
        val_reg      <= val_next;
        slot_res_reg <= slot_res_next;
    end

    // path stack: push rows on the way down, pop them on the way up
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            stack_reg[0] <= ram_rdata;
            for (int i = 1; i < ffca_pkg::LEVELS; i++)
            begin
                stack_reg[i] <= stack_reg[i-1];
            end
        end
        else if (pop)
        begin
            for (int i = 0; i < ffca_pkg::LEVELS - 1; i++)
            begin
                stack_reg[i] <= stack_reg[i+1];
            end
        end
    end

endmodule

// File: rtl/core/first_fit_capacity_allocator_top.sv
// Load: one RAM row read per tree level on the way down, then one row write per level
// on the way up. Allocate: the same walk (no write-back when no slot fits), then the
// result beat; when the root maximum is already too small the beat comes without a walk.
// Throughput: one item at a time, set by those row accesses and by m_tready.
// Reset: a clearing pass writes all 1024 RAM rows to zero with s_tready low;
// slot_count returns to 1024.
// ----------------------------------------------------------------------------
// first_fit_capacity_allocator_top
// First-fit slot allocator over a max tree kept in a row RAM.
// ----------------------------------------------------------------------------
module first_fit_capacity_allocator_top (
    input  logic        clk,
    input  logic        rst_n,
    // input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,   // [10:0] slot_index, [42:11] amount, [47:43] zero
    input  logic        s_tuser,   // [0] opcode
    // result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // [10:0] assigned_slot, [15:11] zero
    // slot_count register
    input  logic        cfg_wr_en,
    input  logic [10:0] cfg_wr_data
);

    logic [ffca_pkg::SLOT_W-1:0] slot_count_reg;
    logic                        m_tvalid_reg, m_tvalid_next;
    logic [ffca_pkg::SLOT_W-1:0] m_slot_reg, m_slot_next;

    ffca_pkg::result_t  res;
    ffca_pkg::ram_req_t ram_req;
    logic               res_ready;
    logic [ffca_pkg::ROW_W-1:0] ram_rdata;

    // Hold slot_count; the host writes it only while no beat is in flight; not enforced here.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot_count_reg <= ffca_pkg::COUNT_RESET;
        end
        else if (cfg_wr_en)
        begin
            slot_count_reg <= cfg_wr_data;
        end
    end

    // Row RAM: row k holds the children of tree node k; the root sits in the walker.
    ffca_row_ram #(
        .DEPTH (ffca_pkg::SLOTS),
        .WIDTH (ffca_pkg::ROW_W)
    ) u_ram (
        .clk   (clk),
        .we    (ram_req.we),
        .waddr (ram_req.waddr),
        .wdata (ram_req.wdata),
        .raddr (ram_req.raddr),
        .rdata (ram_rdata)
    );

    ffca_walker u_walk (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .in_opcode  (s_tuser),
        .in_slot    (s_tdata[10:0]),
        .in_amount  (s_tdata[42:11]),
        .slot_count (slot_count_reg),
        .res        (res),
        .res_ready  (res_ready),
        .ram_req    (ram_req),
        .ram_rdata  (ram_rdata)
    );

    // Output register: take a new result when empty or when the held beat drains.
    assign res_ready = !m_tvalid_reg || m_tready;

    always_comb
    begin
        m_tvalid_next = m_tvalid_reg;
        m_slot_next   = m_slot_reg;
        if (res.valid && res_ready)
        begin
            m_tvalid_next = 1'b1;
            m_slot_next   = res.slot;
        end
        else if (m_tready)
        begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        m_slot_reg <= m_slot_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {5'b0, m_slot_reg};

    // A pending result never coexists with accepting a new beat.
    a_res_not_idle: assert property (@(posedge clk) disable iff (!rst_n)
        res.valid |-> !s_tready)
        else $error("result pending while input is open");

    // The tree RAM is only written while no input beat can be taken.
    a_write_busy: assert property (@(posedge clk) disable iff (!rst_n)
        ram_req.we |-> !s_tready)
        else $error("tree write while idle");

    // A handed-off result shows up on the output next cycle.
    a_res_lands: assert property (@(posedge clk) disable iff (!rst_n)
        (res.valid && res_ready) |=> (m_tvalid && m_tdata[10:0] == $past(res.slot)))
        else $error("result lost in output register");

endmodule
